>>> design/wsa_pkg.sv
// Shared types and codes for the write-back slot allocator.
`default_nettype none

package wsa_pkg;

   // Request action codes as they arrive on the input channel
   localparam logic [1:0] ACT_READ         = 2'd0;
   localparam logic [1:0] ACT_WRITE        = 2'd1;
   localparam logic [1:0] ACT_FLUSH_ALL    = 2'd2;
   localparam logic [1:0] ACT_FLUSH_GLOBAL = 2'd3;

   // Event kinds on the result channel
   localparam logic [1:0] EV_GRANT      = 2'd0;
   localparam logic [1:0] EV_WRITEBACK  = 2'd1;
   localparam logic [1:0] EV_LOAD       = 2'd2;
   localparam logic [1:0] EV_FLUSH_DONE = 2'd3;

   typedef struct packed {
      logic [1:0]         action;
      logic [15:0]        var_name_id;
      logic               var_segment;
      logic signed [15:0] var_offset;
      logic [3:0]         avoid_a;
      logic               avoid_a_en;
      logic [3:0]         avoid_b;
      logic               avoid_b_en;
   } req_type;

   typedef struct packed {
      logic [1:0]         event_kind;
      logic [3:0]         slot_index;
      logic [15:0]        out_name_id;
      logic               out_segment;
      logic signed [15:0] out_offset;
      logic               last_event;
   } rsp_type;

   // Variable key held by one slot
   typedef struct packed {
      logic [15:0] name_id;
      logic        segment;
      logic [15:0] offset;
   } key_type;

   // Classified command between front and engine
   typedef enum logic [1:0] {
      OP_READ,
      OP_WRITE,
      OP_FLUSH_ALL,
      OP_FLUSH_GLOBAL
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      key_type    key;
      logic [3:0] avoid_a;
      logic       avoid_a_en;
      logic [3:0] avoid_b;
      logic       avoid_b_en;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_WRITEBACK,
      ST_LOAD,
      ST_GRANT,
      ST_FLUSH
   } state_type;

endpackage

`default_nettype wire

>>> design/wsa_front.sv
// Front end: accepts requests, decodes them into commands, queues two.
`default_nettype none

module wsa_front
   import wsa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_pop
);

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    dec;
   logic       do_push, do_pop;

   // Decode the request action into a command
   always_comb begin
      dec.key.name_id = req_data.var_name_id;
      dec.key.segment = req_data.var_segment;
      dec.key.offset  = req_data.var_offset;
      dec.avoid_a     = req_data.avoid_a;
      dec.avoid_a_en  = req_data.avoid_a_en;
      dec.avoid_b     = req_data.avoid_b;
      dec.avoid_b_en  = req_data.avoid_b_en;
      case (req_data.action)
         ACT_READ:         dec.op = OP_READ;
         ACT_WRITE:        dec.op = OP_WRITE;
         ACT_FLUSH_ALL:    dec.op = OP_FLUSH_ALL;
         ACT_FLUSH_GLOBAL: dec.op = OP_FLUSH_GLOBAL;
         default:          dec.op = OP_READ;
      endcase
   end

   // Queue control
   assign full      = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

`default_nettype wire

>>> design/wsa_rsp_fifo.sv
// Two-entry result queue between the engine and the result channel.
`default_nettype none

module wsa_rsp_fifo
   import wsa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    ev_push,
   input  rsp_type ev,
   output logic    ev_full,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   rsp_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign ev_full  = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign rsp_data = q_ff[rd_ptr_ff];
   assign do_push  = ev_push && !ev_full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= ev;
      end
   end

endmodule

`default_nettype wire

>>> design/wsa_engine.sv
// Back end: slot table, lookup and victim choice, event sequencer.
`default_nettype none

module wsa_engine
   import wsa_pkg::*;
#(
   parameter int NUM_SLOTS = 16
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    ev_push,
   output rsp_type ev,
   input  logic    ev_full
);

   localparam int SW = $clog2(NUM_SLOTS);
   localparam int CW = (SW > 4) ? SW : 4;
   localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);

   state_type state_ff, state_in;
   cmd_type   cur_ff;

   // Slot table
   logic [NUM_SLOTS-1:0] valid_ff;
   logic [NUM_SLOTS-1:0] dirty_ff;
   key_type              key_ff [NUM_SLOTS];
   logic [SW-1:0]        victim_ff, victim_in;

   // Lookup result
   logic [SW-1:0] slot_ff, slot_in;
   logic          hit_ff, hit_in;
   logic          evict_in;

   logic [NUM_SLOTS-1:0] hit_vec, empty_vec, avoid_vec, clean_vec, wb_vec;
   logic [SW-1:0]        hit_idx, empty_idx, clean_idx, flush_idx;
   logic [SW-1:0]        v1, v2, v3, victim_pick;
   logic [SW-1:0]        rd_idx;
   key_type              rd_key;
   logic                 push_ok;
   logic                 is_read;

   assign push_ok = ev_push && !ev_full;
   assign is_read = (cur_ff.op == OP_READ);

   // Per-slot match, avoid and flush vectors
   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         hit_vec[i]   = valid_ff[i] && (key_ff[i] == cur_ff.key);
         empty_vec[i] = !valid_ff[i];
         avoid_vec[i] = (cur_ff.avoid_a_en && (CW'(cur_ff.avoid_a) == CW'(i))) ||
                        (cur_ff.avoid_b_en && (CW'(cur_ff.avoid_b) == CW'(i)));
         clean_vec[i] = !avoid_vec[i] && !dirty_ff[i];
         wb_vec[i]    = valid_ff[i] && dirty_ff[i] &&
                        ((cur_ff.op == OP_FLUSH_ALL) || key_ff[i].segment);
      end
   end

   // Lowest-index priority encoders
   always_comb begin
      hit_idx   = '0;
      empty_idx = '0;
      clean_idx = '0;
      flush_idx = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (hit_vec[i])   hit_idx   = SW'(i);
         if (empty_vec[i]) empty_idx = SW'(i);
         if (clean_vec[i]) clean_idx = SW'(i);
         if (wb_vec[i])    flush_idx = SW'(i);
      end
   end

   // Round-robin victim: at most two avoided slots to skip
   always_comb begin
      v1 = (victim_ff == LAST_SLOT) ? '0 : victim_ff + 1'b1;
      v2 = (v1 == LAST_SLOT) ? '0 : v1 + 1'b1;
      v3 = (v2 == LAST_SLOT) ? '0 : v2 + 1'b1;
      if (!avoid_vec[v1]) begin
         victim_pick = v1;
      end else if (!avoid_vec[v2]) begin
         victim_pick = v2;
      end else begin
         victim_pick = v3;
      end
   end

   // Slot choice: hit, then empty, then clean unavoided, then victim
   always_comb begin
      hit_in    = 1'b0;
      evict_in  = 1'b0;
      victim_in = victim_ff;
      if (|hit_vec) begin
         slot_in = hit_idx;
         hit_in  = 1'b1;
      end else if (|empty_vec) begin
         slot_in = empty_idx;
      end else if (|clean_vec) begin
         slot_in = clean_idx;
      end else begin
         slot_in   = victim_pick;
         evict_in  = 1'b1;
         victim_in = victim_pick;
      end
   end

   // Single table read port
   assign rd_idx = (state_ff == ST_FLUSH) ? flush_idx : slot_ff;
   assign rd_key = key_ff[rd_idx];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.op == OP_FLUSH_ALL || cmd.op == OP_FLUSH_GLOBAL) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            if (evict_in) begin
               state_in = ST_WRITEBACK;
            end else if (!hit_in && is_read) begin
               state_in = ST_LOAD;
            end else begin
               state_in = ST_GRANT;
            end
         end
         ST_WRITEBACK: begin
            if (push_ok) state_in = is_read ? ST_LOAD : ST_GRANT;
         end
         ST_LOAD: begin
            if (push_ok) state_in = ST_GRANT;
         end
         ST_GRANT: begin
            if (push_ok) state_in = ST_IDLE;
         end
         ST_FLUSH: begin
            if (push_ok && !(|wb_vec)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs: command pop and events
   always_comb begin
      cmd_pop = 1'b0;
      ev_push = 1'b0;
      ev      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd_pop = cmd_valid;
         end
         ST_WRITEBACK: begin
            ev_push        = 1'b1;
            ev.event_kind  = EV_WRITEBACK;
            ev.slot_index  = 4'(slot_ff);
            ev.out_name_id = rd_key.name_id;
            ev.out_segment = rd_key.segment;
            ev.out_offset  = $signed(rd_key.offset);
         end
         ST_LOAD: begin
            ev_push        = 1'b1;
            ev.event_kind  = EV_LOAD;
            ev.slot_index  = 4'(slot_ff);
            ev.out_name_id = cur_ff.key.name_id;
            ev.out_segment = cur_ff.key.segment;
            ev.out_offset  = $signed(cur_ff.key.offset);
         end
         ST_GRANT: begin
            ev_push        = 1'b1;
            ev.event_kind  = EV_GRANT;
            ev.slot_index  = 4'(slot_ff);
            ev.out_name_id = cur_ff.key.name_id;
            ev.out_segment = cur_ff.key.segment;
            ev.out_offset  = $signed(cur_ff.key.offset);
            ev.last_event  = 1'b1;
         end
         ST_FLUSH: begin
            ev_push = 1'b1;
            if (|wb_vec) begin
               ev.event_kind  = EV_WRITEBACK;
               ev.slot_index  = 4'(flush_idx);
               ev.out_name_id = rd_key.name_id;
               ev.out_segment = rd_key.segment;
               ev.out_offset  = $signed(rd_key.offset);
            end else begin
               ev.event_kind = EV_FLUSH_DONE;
               ev.last_event = 1'b1;
            end
         end
         default: begin
            ev_push = 1'b0;
         end
      endcase
   end

   // Control registers and slot marks
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         valid_ff  <= '0;
         dirty_ff  <= '0;
         victim_ff <= LAST_SLOT;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_LOOKUP) begin
            victim_ff <= victim_in;
         end
         // Grant commits the slot
         if (state_ff == ST_GRANT && push_ok) begin
            valid_ff[slot_ff] <= 1'b1;
            if (cur_ff.op == OP_WRITE) begin
               dirty_ff[slot_ff] <= 1'b1;
            end else if (!hit_ff) begin
               dirty_ff[slot_ff] <= 1'b0;
            end
         end
         // Flush empties each slot after its writeback, the rest at the end
         if (state_ff == ST_FLUSH && push_ok) begin
            if (|wb_vec) begin
               valid_ff[flush_idx] <= 1'b0;
               dirty_ff[flush_idx] <= 1'b0;
            end else begin
               valid_ff <= '0;
               dirty_ff <= '0;
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && cmd_valid) begin
         cur_ff <= cmd;
      end
      if (state_ff == ST_LOOKUP) begin
         slot_ff <= slot_in;
         hit_ff  <= hit_in;
      end
      if (state_ff == ST_GRANT && push_ok && !hit_ff) begin
         key_ff[slot_ff] <= cur_ff.key;
      end
   end

endmodule

`default_nettype wire

>>> design/writeback_slot_allocator.sv
// Top level of the write-back slot allocator.
`default_nettype none

// Fully associative table of NUM_SLOTS variable slots with write-back
// eviction. Requests enter through a two-entry command queue and results
// leave through a two-entry result queue, so the request side keeps taking
// items while results wait. One engine serves one request at a time: a get
// steps through command pickup, associative lookup, an optional writeback
// event, an optional load event and the grant; a flush writes back each
// dirty slot in its scope one by one, then reports done. The event steps
// stall while the result queue is full. No clearing pass is needed after
// reset.
module writeback_slot_allocator
   import wsa_pkg::*;
#(
   parameter int NUM_SLOTS = 16
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;
   logic    ev_push;
   rsp_type ev;
   logic    ev_full;

   wsa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   wsa_engine #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .ev_push   (ev_push),
      .ev        (ev),
      .ev_full   (ev_full)
   );

   wsa_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .ev_push  (ev_push),
      .ev       (ev),
      .ev_full  (ev_full),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

>>> test/writeback_slot_allocator_tb.sv
// Self-checking testbench for the write-back slot allocator, with queue handshakes on both sides.
`default_nettype none

module writeback_slot_allocator_tb
   import wsa_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS       = 16;
   localparam int POOL_SIZE   = 24;
   localparam int RAND_ITEMS  = 146;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int LONG_STALL  = 80;

   typedef struct {
      req_type req;
      bit      drain_first;   // hold this item until every result is back
   } stim_item_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    full;
   req_type req_data = '0;
   logic    empty;
   logic    pop = 1'b0;
   rsp_type rsp_data;

   // Shadow copy of the slot table
   logic        tbl_valid [SLOTS];
   logic        tbl_dirty [SLOTS];
   key_type     tbl_key [SLOTS];
   int          victim_ptr;

   stim_item_type stim_items [$];
   rsp_type       expected_events [$];
   key_type       key_pool [POOL_SIZE];

   int error_count = 0;
   int cycle_count = 0;
   int items_taken = 0;
   int events_seen = 0;
   int writeback_count = 0;
   int load_count = 0;
   int flush_count = 0;
   int req_gap = 0;
   int req_calm = 0;
   int rsp_hold = 0;
   int rsp_calm = 0;
   int long_stall = 0;
   bit long_stall_done = 1'b0;

   writeback_slot_allocator #(.NUM_SLOTS(SLOTS)) u_top (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Gap length: mostly none or short, a few long, plus calm stretches
   function automatic int pick_gap(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(99);
      if (roll < 4) begin
         calm = $urandom_range(30, 10);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic key_type make_key(logic [15:0] name_id, logic segment,
                                        logic [15:0] offset);
      key_type k;
      k.name_id = name_id;
      k.segment = segment;
      k.offset  = offset;
      return k;
   endfunction

   function automatic void add_event(logic [1:0] kind, int slot, key_type k,
                                     logic last);
      rsp_type ev;
      ev.event_kind  = kind;
      ev.slot_index  = slot[3:0];
      ev.out_name_id = k.name_id;
      ev.out_segment = k.segment;
      ev.out_offset  = k.offset;
      ev.last_event  = last;
      expected_events.push_back(ev);
      if (kind == EV_WRITEBACK) writeback_count++;
      if (kind == EV_LOAD) load_count++;
   endfunction

   function automatic bit slot_avoided(req_type r, int i);
      return (r.avoid_a_en && i == int'(r.avoid_a)) ||
             (r.avoid_b_en && i == int'(r.avoid_b));
   endfunction

   // Apply one accepted request to the shadow table and queue its events
   function automatic void model_request(req_type r);
      key_type k;
      int      i;
      int      slot;
      bit      hit;
      bit      got;
      k = make_key(r.var_name_id, r.var_segment, r.var_offset);
      slot = 0;
      hit = 1'b0;
      got = 1'b0;
      if (r.action == ACT_FLUSH_ALL || r.action == ACT_FLUSH_GLOBAL) begin
         flush_count++;
         for (i = 0; i < SLOTS; i++) begin
            if (tbl_valid[i]) begin
               // stack slots are dropped silently on end-of-function flush
               if ((r.action == ACT_FLUSH_ALL || tbl_key[i].segment) && tbl_dirty[i])
                  add_event(EV_WRITEBACK, i, tbl_key[i], 1'b0);
               tbl_valid[i] = 1'b0;
               tbl_dirty[i] = 1'b0;
            end
         end
         add_event(EV_FLUSH_DONE, 0, '0, 1'b1);
         return;
      end
      for (i = 0; i < SLOTS && !hit; i++) begin
         if (tbl_valid[i] && tbl_key[i] == k) begin
            slot = i;
            hit = 1'b1;
         end
      end
      if (!hit) begin
         for (i = 0; i < SLOTS && !got; i++) begin
            if (!tbl_valid[i]) begin
               slot = i;
               got = 1'b1;
            end
         end
         for (i = 0; i < SLOTS && !got; i++) begin
            if (!slot_avoided(r, i) && !tbl_dirty[i]) begin
               slot = i;
               got = 1'b1;
            end
         end
         if (!got) begin
            // round-robin over dirty slots, skipping avoided ones
            for (i = 0; i < SLOTS; i++) begin
               victim_ptr = (victim_ptr + 1) % SLOTS;
               if (!slot_avoided(r, victim_ptr)) break;
            end
            slot = victim_ptr;
            if (tbl_valid[slot] && tbl_dirty[slot])
               add_event(EV_WRITEBACK, slot, tbl_key[slot], 1'b0);
            tbl_dirty[slot] = 1'b0;
         end
         tbl_valid[slot] = 1'b1;
         tbl_key[slot] = k;
         if (r.action == ACT_READ) begin
            add_event(EV_LOAD, slot, k, 1'b0);
            tbl_dirty[slot] = 1'b0;
         end
      end
      if (r.action == ACT_WRITE) tbl_dirty[slot] = 1'b1;
      add_event(EV_GRANT, slot, k, 1'b1);
   endfunction

   task automatic add_req(logic [1:0] action, key_type k, logic [3:0] av_a, logic a_en,
                          logic [3:0] av_b, logic b_en, bit drain_first);
      stim_item_type s;
      s.req.action      = action;
      s.req.var_name_id = k.name_id;
      s.req.var_segment = k.segment;
      s.req.var_offset  = k.offset;
      s.req.avoid_a     = av_a;
      s.req.avoid_a_en  = a_en;
      s.req.avoid_b     = av_b;
      s.req.avoid_b_en  = b_en;
      s.drain_first     = drain_first;
      stim_items.push_back(s);
   endtask

   task automatic check_event(rsp_type got, rsp_type exp);
      if (got.event_kind !== exp.event_kind) begin
         $error("event_kind: expected %0d, got %0d", exp.event_kind, got.event_kind);
         error_count++;
      end
      if (got.slot_index !== exp.slot_index) begin
         $error("slot_index: expected %0d, got %0d", exp.slot_index, got.slot_index);
         error_count++;
      end
      if (got.out_name_id !== exp.out_name_id) begin
         $error("out_name_id: expected %0h, got %0h", exp.out_name_id, got.out_name_id);
         error_count++;
      end
      if (got.out_segment !== exp.out_segment) begin
         $error("out_segment: expected %0d, got %0d", exp.out_segment, got.out_segment);
         error_count++;
      end
      if (got.out_offset !== exp.out_offset) begin
         $error("out_offset: expected %0d, got %0d", exp.out_offset, got.out_offset);
         error_count++;
      end
      if (got.last_event !== exp.last_event) begin
         $error("last_event: expected %0d, got %0d", exp.last_event, got.last_event);
         error_count++;
      end
   endtask

   // Request driver: predicts on acceptance, then offers the next pending item
   always @(posedge clock) begin
      logic next_push;
      if (reset) begin
         push <= 1'b0;
      end else begin
         next_push = push;
         if (push && !full) begin
            model_request(req_data);
            items_taken++;
            void'(stim_items.pop_front());
            req_gap = pick_gap(req_calm);
         end
         if (!push || !full) begin
            next_push = 1'b0;
            if (req_gap > 0) begin
               req_gap--;
            end else if (stim_items.size() > 0 &&
                         !(stim_items[0].drain_first && expected_events.size() > 0)) begin
               next_push = 1'b1;
               req_data <= stim_items[0].req;
            end
         end
         push <= next_push;
      end
   end

   // Result monitor: checks each popped item, stalls at random
   always @(posedge clock) begin
      rsp_type exp;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            events_seen++;
            if (expected_events.size() == 0) begin
               $error("result with nothing expected: kind %0d slot %0d",
                      rsp_data.event_kind, rsp_data.slot_index);
               error_count++;
            end else begin
               exp = expected_events.pop_front();
               check_event(rsp_data, exp);
            end
            rsp_hold = pick_gap(rsp_calm);
            // one long hold-off so the block backs up into the request side
            if (!long_stall_done && events_seen >= 150) begin
               long_stall_done = 1'b1;
               long_stall = LONG_STALL;
            end
         end
         if (long_stall > 0) begin
            long_stall--;
            pop <= 1'b0;
         end else if (rsp_hold > 0) begin
            rsp_hold--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected",
                  cycle_count, expected_events.size());
         $display("FAIL writeback_slot_allocator");
         $finish;
      end
   end

   initial begin
      key_type key_a, key_b;
      key_type k;
      int      i;
      int      roll;
      logic [1:0] act;

      for (i = 0; i < SLOTS; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_dirty[i] = 1'b0;
         tbl_key[i]   = '0;
      end
      victim_ptr = SLOTS - 1;

      // Directed part: hits, misses on each key field, avoids, both flushes
      key_a = make_key(16'h0000, 1'b0, 16'h8000);
      key_b = make_key(16'hFFFF, 1'b1, 16'h7FFF);
      add_req(ACT_READ,  key_a, 4'd0, 1'b0, 4'd0, 1'b0, 1'b0);
      add_req(ACT_WRITE, key_a, 4'd0, 1'b0, 4'd0, 1'b0, 1'b0);
      add_req(ACT_READ,  key_a, 4'hF, 1'b0, 4'hF, 1'b0, 1'b0);  // hit keeps dirty
      add_req(ACT_WRITE, key_b, 4'd0, 1'b0, 4'd0, 1'b0, 1'b0);  // new slot, no load
      add_req(ACT_READ, make_key(16'h0000, 1'b1, 16'h8000), 4'd0, 1'b0, 4'd0, 1'b0, 1'b0);
      add_req(ACT_READ, make_key(16'h0000, 1'b0, 16'h8001), 4'd0, 1'b0, 4'd0, 1'b0, 1'b0);
      add_req(ACT_READ, make_key(16'h0001, 1'b0, 16'h8000), 4'd0, 1'b0, 4'd0, 1'b0, 1'b0);
      for (i = 0; i < 11; i++)
         add_req(ACT_WRITE, make_key(16'(16'h0100 + i), i[0], 16'(i * 4 - 8)),
                 4'd0, 1'b0, 4'd0, 1'b0, 1'b0);
      // table full: clean victims 4 then 3, then round-robin past avoided slot 0
      add_req(ACT_WRITE, make_key(16'h5A5A, 1'b1, 16'h0010), 4'd2, 1'b1, 4'd3, 1'b1, 1'b0);
      add_req(ACT_WRITE, make_key(16'hA5A5, 1'b0, 16'hFFF0), 4'd2, 1'b1, 4'd4, 1'b1, 1'b0);
      add_req(ACT_WRITE, make_key(16'h1234, 1'b1, 16'h0000), 4'd2, 1'b1, 4'd0, 1'b1, 1'b0);
      add_req(ACT_READ,  key_a, 4'd0, 1'b1, 4'd0, 1'b1, 1'b0);
      add_req(ACT_FLUSH_ALL,    '0, 4'd0, 1'b0, 4'd0, 1'b0, 1'b0);
      add_req(ACT_FLUSH_GLOBAL, '0, 4'd0, 1'b0, 4'd0, 1'b0, 1'b0);

      // Key pool larger than the table, with near-miss variants of some keys
      for (i = 0; i < 16; i++)
         key_pool[i] = make_key(16'($urandom), 1'($urandom), 16'($urandom));
      for (i = 16; i < POOL_SIZE; i++) begin
         k = key_pool[i - 16];
         case (i % 3)
            0: k.segment = ~k.segment;
            1: k.offset  = k.offset + 16'd1;
            default: k.name_id = k.name_id ^ 16'h0001;
         endcase
         key_pool[i] = k;
      end

      // Random part: mostly gets on pooled keys, some flushes and stray keys
      for (i = 0; i < RAND_ITEMS; i++) begin
         roll = $urandom_range(99);
         if (roll < 4) act = ACT_FLUSH_ALL;
         else if (roll < 8) act = ACT_FLUSH_GLOBAL;
         else if (roll < 54) act = ACT_READ;
         else act = ACT_WRITE;
         if ($urandom_range(99) < 85)
            k = key_pool[$urandom_range(POOL_SIZE - 1)];
         else
            k = make_key(16'($urandom), 1'($urandom), 16'($urandom));
         add_req(act, k, 4'($urandom), 1'($urandom), 4'($urandom), 1'($urandom),
                 i == RAND_ITEMS / 2);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (stim_items.size() > 0 || push) @(posedge clock);
      while (expected_events.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d requests (%0d flushes) and %0d result items",
               items_taken, flush_count, events_seen);
      $display("  including %0d writebacks and %0d loads, %0d mismatches",
               writeback_count, load_count, error_count);
      if (error_count == 0) begin
         $display("PASS writeback_slot_allocator");
      end else begin
         $display("FAIL writeback_slot_allocator");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
design/wsa_pkg.sv
design/wsa_front.sv
design/wsa_rsp_fifo.sv
design/wsa_engine.sv
design/writeback_slot_allocator.sv
test/writeback_slot_allocator_tb.sv
